// ===== hw/rtl/eahs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eahs_pkg
// shared types and codes for the eight-way min-heap sorter
// ----------------------------------------------------------------------------
package eahs_pkg;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [31:0] KEY_ABSENT = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_RD_ROOT,
        S_EX_RD_LAST,
        S_EX_GET_LAST,
        S_DN_RD,
        S_DN_SCAN,
        S_DN_DECIDE,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/eight_ary_min_heap_sorter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eight_ary_min_heap_sorter
// d-ary min-heap of 32-bit keys held in one single-port synchronous memory
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears one cycle wide with o_valid, and cannot be held off. All heap work
// goes through one memory port with registered read data, one access per
// cycle. An insert moves its key up the heap one level at a time; an extract
// examines all ARITY children of each level on its way down, and a full heap
// holds CAPACITY keys, 1024 by default. A dropped insert or an extract from an
// empty heap goes straight to its result. The store needs no clearing after
// reset.
module eight_ary_min_heap_sorter #(
    parameter int CAPACITY = 1024,
    parameter int ARITY    = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    output logic [31:0]      o_key_out,
    output logic [1:0]       o_status,
    output logic [10:0]      o_remaining
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (ARITY > 1) ? $clog2(ARITY) : 1;
    localparam int PW = CW + KW + 1;

    logic [31:0] mem [CAPACITY];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    eahs_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic [31:0]   r_key, n_key;
    logic [31:0]   r_best_key, n_best_key;
    logic [CW-1:0] r_best, n_best;
    logic [KW:0]   r_k, n_k;
    logic [31:0]   r_out_key, n_out_key;
    logic [1:0]    r_out_status, n_out_status;
    logic          r_valid, n_valid;

    logic [CW-1:0] parent;
    logic [PW-1:0] first_w;
    logic [PW-1:0] child_w;
    logic [31:0]   child_key;

    always_comb begin
        parent  = CW'((r_pos - CW'(1)) / ARITY);
        first_w = PW'(r_pos) * PW'(ARITY) + PW'(1);
        child_w = first_w + PW'(r_k) - PW'(1);
        child_key = (child_w < PW'(r_count)) ? r_rdata : eahs_pkg::KEY_ABSENT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eahs_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_best_key   <= n_best_key;
        r_best       <= n_best;
        r_k          <= n_k;
        r_out_key    <= n_out_key;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_key        = r_key;
        n_best_key   = r_best_key;
        n_best       = r_best;
        n_k          = r_k;
        n_out_key    = r_out_key;
        n_out_status = r_out_status;
        n_valid      = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = AW'(r_pos);
        mem_wdata    = r_key;
        case (r_state)
            eahs_pkg::S_IDLE: begin
                if (start) begin
                    n_out_key    = '0;
                    n_out_status = eahs_pkg::STATUS_OK;
                    if (i_command == eahs_pkg::CMD_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_out_status = eahs_pkg::STATUS_FULL;
                            n_state      = eahs_pkg::S_DONE;
                        end else begin
                            n_key   = i_value;
                            n_pos   = r_count;
                            n_count = r_count + CW'(1);
                            n_state = eahs_pkg::S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_out_status = eahs_pkg::STATUS_EMPTY;
                            n_state      = eahs_pkg::S_DONE;
                        end else begin
                            n_pos   = '0;
                            n_state = eahs_pkg::S_EX_RD_ROOT;
                        end
                    end
                end
            end
            eahs_pkg::S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = eahs_pkg::S_DONE;
                end else begin
                    mem_addr = AW'(parent);
                    n_state  = eahs_pkg::S_UP_CMP;
                end
            end
            eahs_pkg::S_UP_CMP: begin
                if (r_key < r_rdata) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata;
                    n_pos     = parent;
                    n_state   = eahs_pkg::S_UP_RD;
                end else begin
                    mem_we  = 1'b1;
                    n_state = eahs_pkg::S_DONE;
                end
            end
            eahs_pkg::S_EX_RD_ROOT: begin
                mem_addr = '0;
                n_count  = r_count - CW'(1);
                n_state  = eahs_pkg::S_EX_RD_LAST;
            end
            eahs_pkg::S_EX_RD_LAST: begin
                n_out_key = r_rdata;
                if (r_count == '0) begin
                    n_state = eahs_pkg::S_DONE;
                end else begin
                    mem_addr = AW'(r_count);
                    n_state  = eahs_pkg::S_EX_GET_LAST;
                end
            end
            eahs_pkg::S_EX_GET_LAST: begin
                n_key   = r_rdata;
                n_pos   = '0;
                n_state = eahs_pkg::S_DN_RD;
            end
            eahs_pkg::S_DN_RD: begin
                if (first_w >= PW'(r_count)) begin
                    mem_we  = 1'b1;
                    n_state = eahs_pkg::S_DONE;
                end else begin
                    mem_addr   = AW'(first_w);
                    n_k        = (KW+1)'(1);
                    n_best_key = eahs_pkg::KEY_ABSENT;
                    n_best     = CW'(first_w);
                    n_state    = eahs_pkg::S_DN_SCAN;
                end
            end
            eahs_pkg::S_DN_SCAN: begin
                mem_addr = AW'(child_w + PW'(1));
                if (r_k == (KW+1)'(1) || child_key < r_best_key) begin
                    n_best_key = child_key;
                    n_best     = CW'(child_w);
                end
                if (r_k == (KW+1)'(ARITY)) begin
                    n_state = eahs_pkg::S_DN_DECIDE;
                end else begin
                    n_k = r_k + (KW+1)'(1);
                end
            end
            eahs_pkg::S_DN_DECIDE: begin
                if (r_best_key < r_key) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_best_key;
                    n_pos     = r_best;
                    n_state   = eahs_pkg::S_DN_RD;
                end else begin
                    mem_we  = 1'b1;
                    n_state = eahs_pkg::S_DONE;
                end
            end
            eahs_pkg::S_DONE: begin
                n_valid = 1'b1;
                n_state = eahs_pkg::S_IDLE;
            end
            default: begin
                n_state = eahs_pkg::S_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != eahs_pkg::S_IDLE);
    assign o_valid     = r_valid;
    assign o_key_out   = r_out_key;
    assign o_status    = r_out_status;
    assign o_remaining = 11'(r_count);

endmodule
`default_nettype wire

// ===== hw/rtl/eahs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eahs_checker
// port-level checks for the heap sorter
// ----------------------------------------------------------------------------
module eahs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [31:0] o_key_out,
    input wire logic [1:0]  o_status,
    input wire logic [10:0] o_remaining
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("no busy after accept");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result held two cycles");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == eahs_pkg::STATUS_OK ||
                     o_status == eahs_pkg::STATUS_FULL ||
                     o_status == eahs_pkg::STATUS_EMPTY))
        else $error("bad status");

    a_err_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != eahs_pkg::STATUS_OK) |-> (o_key_out == 32'd0))
        else $error("key on failed item");

    a_empty_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == eahs_pkg::STATUS_EMPTY) |-> (o_remaining == 11'd0))
        else $error("empty with entries");

endmodule

bind eight_ary_min_heap_sorter eahs_checker u_eahs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_key_out(o_key_out),
    .o_status(o_status), .o_remaining(o_remaining)
);
`default_nettype wire

// ===== tb/eight_ary_min_heap_sorter_checker.sv =====
// ----------------------------------------------------------------------------
// eight_ary_min_heap_sorter_checker
// watches the command and result channels, keeps its own 8-way min-heap and
// compares every result field with the oldest predicted one
// ----------------------------------------------------------------------------
module eight_ary_min_heap_sorter_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic        i_command,
    input  wire logic [31:0] i_value,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_key_out,
    input  wire logic [1:0]  i_status,
    input  wire logic [10:0] i_remaining,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen
);

    localparam int HEAP_DEPTH = 1024;
    localparam int FAN_OUT    = 8;

    typedef struct packed {
        logic [31:0] key_out;
        logic [1:0]  status;
        logic [10:0] remaining;
    } t_heap_result;

    logic [31:0]  model_heap [HEAP_DEPTH];
    int           model_count;
    t_heap_result expected_results [$];

    function automatic t_heap_result heap_apply(input logic cmd, input logic [31:0] val);
        t_heap_result r;
        int pos;
        int up;
        int first;
        int best;
        logic [31:0] mv;
        logic [31:0] best_key;
        logic [31:0] ck;
        r = '0;
        if (cmd == eahs_pkg::CMD_INSERT) begin
            if (model_count >= HEAP_DEPTH) begin
                r.status = eahs_pkg::STATUS_FULL;
            end else begin
                pos = model_count;
                model_count++;
                while (pos > 0) begin
                    up = (pos - 1) / FAN_OUT;
                    if (!(val < model_heap[up])) break;
                    model_heap[pos] = model_heap[up];
                    pos = up;
                end
                model_heap[pos] = val;
            end
        end else begin
            if (model_count == 0) begin
                r.status = eahs_pkg::STATUS_EMPTY;
            end else begin
                r.key_out = model_heap[0];
                model_count--;
                if (model_count > 0) begin
                    mv = model_heap[model_count];
                    pos = 0;
                    forever begin
                        first = pos * FAN_OUT + 1;
                        if (first >= model_count) break;
                        best = first;
                        best_key = model_heap[first];
                        for (int k = 1; k < FAN_OUT; k++) begin
                            ck = (first + k < model_count) ? model_heap[first + k]
                                                           : eahs_pkg::KEY_ABSENT;
                            if (ck < best_key) begin
                                best_key = ck;
                                best = first + k;
                            end
                        end
                        if (!(best_key < mv)) break;
                        model_heap[pos] = best_key;
                        pos = best;
                    end
                    model_heap[pos] = mv;
                end
            end
        end
        r.remaining = model_count[10:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_heap_result exp_r;
        if (!i_rst_n) begin
            model_count = 0;
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_pending <= 0;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding: key %h", i_key_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.key_out !== i_key_out) begin
                        $error("key_out expected %h actual %h", exp_r.key_out, i_key_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (exp_r.status !== i_status) begin
                        $error("status expected %0d actual %0d", exp_r.status, i_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (exp_r.remaining !== i_remaining) begin
                        $error("remaining expected %0d actual %0d",
                               exp_r.remaining, i_remaining);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_results.push_back(heap_apply(i_command, i_value));
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/eight_ary_min_heap_sorter_tb.sv =====
// ----------------------------------------------------------------------------
// eight_ary_min_heap_sorter_tb
// drives insert and extract items into the heap sorter: directed corner
// cases, one long sort run, then random sort runs and mixed traffic
// ----------------------------------------------------------------------------
module eight_ary_min_heap_sorter_tb;

    localparam int BIG_RUN     = 150;
    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        i_command = eahs_pkg::CMD_INSERT;
    logic [31:0] i_value = '0;
    logic        busy;
    logic        o_valid;
    logic [31:0] o_key_out;
    logic [1:0]  o_status;
    logic [10:0] o_remaining;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          cycle_count = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;

    always #5 i_clk = ~i_clk;

    eight_ary_min_heap_sorter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_command  (i_command),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_key_out  (o_key_out),
        .o_status   (o_status),
        .o_remaining(o_remaining)
    );

    eight_ary_min_heap_sorter_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_valid       (o_valid),
        .i_key_out     (o_key_out),
        .i_status      (o_status),
        .i_remaining   (o_remaining),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results_seen(results_seen)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[eight_ary_min_heap_sorter] ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [31:0] val);
        @(posedge i_clk);
        while (!calm && $urandom_range(99) < 26) @(posedge i_clk);
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        items_sent++;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_item(eahs_pkg::CMD_EXTRACT, 32'h0);
        send_item(eahs_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        send_item(eahs_pkg::CMD_EXTRACT, 32'hFFFF_FFFF);
        send_item(eahs_pkg::CMD_EXTRACT, 32'h0);
        send_item(eahs_pkg::CMD_INSERT, 32'h0);
        send_item(eahs_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        send_item(eahs_pkg::CMD_INSERT, 32'h5555_5555);
        send_item(eahs_pkg::CMD_INSERT, 32'hAAAA_AAAA);
        send_item(eahs_pkg::CMD_INSERT, 32'h0);
        for (int k = 0; k < 6; k++) send_item(eahs_pkg::CMD_EXTRACT, 32'hFFFF_FFFF);

        // one long sort run with no idling, then one extract past empty
        calm = 1'b1;
        for (int k = 0; k < BIG_RUN; k++) send_item(eahs_pkg::CMD_INSERT, pick_key());
        for (int k = 0; k < BIG_RUN + 1; k++) send_item(eahs_pkg::CMD_EXTRACT, $urandom);
        calm = 1'b0;

        // wait for every result before random traffic
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // random sort runs
        while (items_sent < 360) begin
            n = $urandom_range(1, 24);
            for (int k = 0; k < n; k++) send_item(eahs_pkg::CMD_INSERT, pick_key());
            for (int k = 0; k < n; k++) send_item(eahs_pkg::CMD_EXTRACT, $urandom);
        end

        // mixed noise
        for (int k = 0; k < 90; k++) send_item(logic'($urandom_range(1)), pick_key());

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("sent %0d items, saw %0d results: a %0d-key sort, short random sorts,",
                 items_sent, results_seen, BIG_RUN);
        $display("extracts from an empty heap and mixed insert and extract traffic");
        if (fail_count == 0) begin
            $display("[eight_ary_min_heap_sorter] OK");
        end else begin
            $display("[eight_ary_min_heap_sorter] ERROR");
        end
        $finish;
    end

endmodule
